@@ hw/rtl/crcfb_pkg.sv @@
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the frame builder.
// Used by crcfb_front, crcfb_fifo, crcfb_back and crc16_frame_builder; depends on nothing.
package crcfb_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Command queue between the front and back parts.
    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;
    localparam int FIFO_CW    = FIFO_AW + 1;

    // Step counter inside one command in the back part.
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    // Index of the last payload byte of each command kind.
    localparam step_t START_LAST_STEP = step_t'(3);
    localparam step_t DATA_LAST_STEP  = step_t'(0);

    // A start command carries {length, sequence}; a data command carries its byte in [7:0].
    typedef struct packed {
        logic        is_start;
        logic        trailer;
        logic [31:0] payload;
    } cmd_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/crc16_frame_builder.sv @@
// Link frame builder with a CRC-16/CCITT-FALSE trailer; top level.
// Depends on crcfb_pkg, crcfb_front, crcfb_fifo and crcfb_back.
//
// A start transaction (kind 0) opens a frame and produces the 16-bit sequence number and
// the 16-bit message length, both low byte first; each data transaction (kind 1) inside a
// frame produces its byte, and after the last message byte the block appends the CRC low
// byte and then the high byte, which carries frame_end. A zero-length start produces its
// four header bytes, then the CRC; data outside a frame is dropped and a start inside a
// frame abandons it. The front part accepts one transaction per cycle while its four-entry
// command queue has room. The back part writes one result byte per cycle into the output
// register while a command waits and the output is not stalled; a data item yields one
// byte, a start four and a closing item two more; the single-byte output sets the rate.
module crc16_frame_builder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [15:0] s_msg_length,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_frame_end
);

    logic            push, full, pop, empty;
    crcfb_pkg::cmd_t push_cmd, head_cmd;

    crcfb_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_msg_length (s_msg_length),
        .s_data_byte  (s_data_byte),
        .push         (push),
        .push_cmd     (push_cmd),
        .full         (full)
    );

    crcfb_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (empty)
    );

    crcfb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_cmd    (head_cmd),
        .empty       (empty),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_frame_end (m_frame_end)
    );

endmodule

@@ hw/rtl/crcfb_fifo.sv @@
// Small command queue that decouples the frame builder's front and back parts.
// Depends on crcfb_pkg for the command type and depth.
module crcfb_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  crcfb_pkg::cmd_t   push_cmd,
    output logic              full,
    input  logic              pop,
    output crcfb_pkg::cmd_t   head_cmd,
    output logic              empty
);

    crcfb_pkg::cmd_t                    entry_reg [crcfb_pkg::FIFO_DEPTH];
    logic [crcfb_pkg::FIFO_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [crcfb_pkg::FIFO_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [crcfb_pkg::FIFO_CW-1:0]      count_reg, count_next;

    assign full     = (count_reg == crcfb_pkg::FIFO_CW'(crcfb_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + crcfb_pkg::FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + crcfb_pkg::FIFO_AW'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + crcfb_pkg::FIFO_CW'(1);
            2'b01:   count_next = count_reg - crcfb_pkg::FIFO_CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/crcfb_front.sv @@
// Front part of the frame builder: accepts input transactions, keeps the frame bookkeeping
// and queues start or data commands. Depends on crcfb_pkg.
module crcfb_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  logic [15:0]       s_msg_length,
    input  logic [7:0]        s_data_byte,
    output logic              push,
    output crcfb_pkg::cmd_t   push_cmd,
    input  logic              full
);

    logic [15:0] seq_reg, seq_next;
    logic [15:0] remaining_reg, remaining_next;
    logic        open_reg, open_next;
    logic        accept;
    logic [15:0] remaining_dec;

    assign s_ready       = !full;
    assign accept        = s_valid && s_ready;
    assign remaining_dec = remaining_reg - 16'd1;

    always_comb begin
        seq_next       = seq_reg;
        remaining_next = remaining_reg;
        open_next      = open_reg;
        push           = 1'b0;
        push_cmd       = '0;
        if (accept) begin
            if (!s_kind) begin
                // A start abandons any open frame and begins a new one.
                seq_next          = seq_reg + 16'd1;
                remaining_next    = s_msg_length;
                open_next         = (s_msg_length != 16'd0);
                push              = 1'b1;
                push_cmd.is_start = 1'b1;
                push_cmd.trailer  = (s_msg_length == 16'd0);
                push_cmd.payload  = {s_msg_length, seq_reg};
            end else if (open_reg) begin
                remaining_next    = remaining_dec;
                open_next         = (remaining_dec != 16'd0);
                push              = 1'b1;
                push_cmd.is_start = 1'b0;
                push_cmd.trailer  = (remaining_dec == 16'd0);
                push_cmd.payload  = {24'd0, s_data_byte};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg       <= '0;
            remaining_reg <= '0;
            open_reg      <= 1'b0;
        end else begin
            seq_reg       <= seq_next;
            remaining_reg <= remaining_next;
            open_reg      <= open_next;
        end
    end

endmodule

@@ hw/rtl/crcfb_back.sv @@
// Back part of the frame builder: serializes queued commands into bytes, runs the CRC and
// drives the registered result channel. Depends on crcfb_pkg.
module crcfb_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  crcfb_pkg::cmd_t   head_cmd,
    input  logic              empty,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_frame_end
);

    crcfb_pkg::step_t step_reg, step_next;
    logic [15:0]      crc_reg, crc_next;
    logic             m_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             frame_end_reg;

    crcfb_pkg::step_t last_step;
    logic             advance, work;
    logic             in_payload, trailer_lo, trailer_hi;
    logic [7:0]       payload_byte, byte_sel;
    logic [15:0]      crc_in, crc_folded;

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_frame_end = frame_end_reg;

    // The output register can load whenever it is empty or being drained this cycle.
    assign advance = !m_valid_reg || m_ready;
    assign work    = advance && !empty;

    always_comb begin
        last_step  = head_cmd.is_start ? crcfb_pkg::START_LAST_STEP
                                       : crcfb_pkg::DATA_LAST_STEP;
        in_payload = (step_reg <= last_step);
        trailer_lo = (step_reg == last_step + crcfb_pkg::step_t'(1));
        trailer_hi = (step_reg == last_step + crcfb_pkg::step_t'(2));

        unique case (step_reg[1:0])
            2'd0: payload_byte = head_cmd.payload[7:0];
            2'd1: payload_byte = head_cmd.payload[15:8];
            2'd2: payload_byte = head_cmd.payload[23:16];
            2'd3: payload_byte = head_cmd.payload[31:24];
        endcase

        // A start command restarts the CRC on its first header byte.
        crc_in     = (head_cmd.is_start && step_reg == '0) ? crcfb_pkg::CRC_INIT : crc_reg;
        crc_folded = crcfb_pkg::crc_byte(crc_in, payload_byte);

        priority if (in_payload) begin
            byte_sel = payload_byte;
            crc_next = crc_folded;
        end else if (trailer_lo) begin
            byte_sel = crc_reg[7:0];
            crc_next = crc_reg;
        end else begin
            byte_sel = crc_reg[15:8];
            crc_next = crcfb_pkg::CRC_INIT;
        end

        pop       = work && ((in_payload && step_reg == last_step && !head_cmd.trailer)
                             || trailer_hi);
        step_next = pop ? '0 : step_reg + crcfb_pkg::step_t'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            crc_reg     <= crcfb_pkg::CRC_INIT;
            m_valid_reg <= 1'b0;
        end else if (work) begin
            step_reg    <= step_next;
            crc_reg     <= crc_next;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (work) begin
            out_byte_reg  <= byte_sel;
            frame_end_reg <= trailer_hi;
        end
    end

endmodule
